// ----- sv/mexp_pkg.sv -----
package mexp_pkg;

    // config register indexes
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS  = 2'd1;

    // status of the shared modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mexp_mm_stat_t;

endpackage

// ----- sv/mexp_modmul.sv -----
module mexp_modmul import mexp_pkg::*; #(
    parameter int unsigned WORD_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] op_a,
    input  logic [WORD_BITS-1:0] op_b,
    input  logic [WORD_BITS-1:0] op_m,
    output mexp_mm_stat_t        stat,
    output logic [WORD_BITS-1:0] product
);

    localparam int unsigned CNT_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    logic [WORD_BITS-1:0] a_reg;
    logic [WORD_BITS-1:0] b_reg;
    logic [WORD_BITS-1:0] m_reg;
    logic [WORD_BITS-1:0] r_reg, r_next;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [WORD_BITS:0] dbl, dbl_red, add, add_red, m_ext;

    // interleaved shift-add: r = 2r mod m, then r = r + a mod m if the bit of b is set
    always_comb begin
        m_ext   = {1'b0, m_reg};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        add     = {1'b0, dbl_red[WORD_BITS-1:0]}
                  + (b_reg[WORD_BITS-1] ? {1'b0, a_reg} : '0);
        add_red = (add >= m_ext) ? (add - m_ext) : add;
        r_next  = add_red[WORD_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            m_reg   <= op_m;
            r_reg   <= '0;
            cnt_reg <= CNT_BITS'(WORD_BITS - 1);
        end else if (busy_reg) begin
            r_reg   <= r_next;
            b_reg   <= {b_reg[WORD_BITS-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = r_reg;

endmodule

// ----- sv/mexp_seq.sv -----
module mexp_seq import mexp_pkg::*; #(
    parameter int unsigned WORD_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_accept,
    input  logic [WORD_BITS-1:0] message,
    input  logic [WORD_BITS-1:0] exponent,
    input  logic [WORD_BITS-1:0] modulus,
    output logic                 idle,
    output logic                 mm_start,
    output logic [WORD_BITS-1:0] mm_a,
    output logic [WORD_BITS-1:0] mm_b,
    input  mexp_mm_stat_t        mm_stat,
    input  logic [WORD_BITS-1:0] mm_product,
    output logic                 res_valid,
    input  logic                 res_taken,
    output logic [WORD_BITS-1:0] res_value,
    output logic                 res_error
);

    localparam int unsigned BIT_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_LAUNCH = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_SQR    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] base_reg, base_next;
    logic [BIT_BITS-1:0]  bit_reg, bit_next;
    logic                 err_reg, err_next;

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        bit_next   = bit_reg;
        err_next   = err_reg;
        mm_start   = 1'b0;
        mm_a       = base_reg;
        mm_b       = base_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    if (exponent == '0) begin
                        acc_next   = WORD_BITS'(1);
                        err_next   = 1'b0;
                        state_next = S_DONE;
                    end else if (modulus == '0) begin
                        acc_next   = '0;
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        // message mod modulus as 1 * message
                        mm_start   = 1'b1;
                        mm_a       = WORD_BITS'(1);
                        mm_b       = message;
                        err_next   = 1'b0;
                        bit_next   = '0;
                        state_next = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (mm_stat.done) begin
                    base_next  = mm_product;
                    acc_next   = WORD_BITS'(1);
                    state_next = S_LAUNCH;
                end
            end
            S_LAUNCH: begin
                mm_start = 1'b1;
                if (exponent[bit_reg]) begin
                    mm_a       = acc_reg;
                    state_next = S_MUL;
                end else begin
                    state_next = S_SQR;
                end
            end
            S_MUL: begin
                if (mm_stat.done) begin
                    acc_next   = mm_product;
                    mm_start   = 1'b1;
                    state_next = S_SQR;
                end
            end
            S_SQR: begin
                if (mm_stat.done) begin
                    base_next = mm_product;
                    if (bit_reg == BIT_BITS'(WORD_BITS - 1)) begin
                        state_next = S_DONE;
                    end else begin
                        bit_next   = bit_reg + 1'b1;
                        state_next = S_LAUNCH;
                    end
                end
            end
            S_DONE: begin
                if (res_taken) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        base_reg <= base_next;
        bit_reg  <= bit_next;
        err_reg  <= err_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_value = acc_reg;
    assign res_error = err_reg;

endmodule

// ----- sv/modular_exponentiation_top.sv -----
// modular exponentiation: result = message ^ exponent mod modulus
// config channel: cfg_index 0 writes the exponent, 1 the modulus, other indexes
//   are ignored; always ready, write only while the block is idle
// input channel s_*: one message per beat, taken only when no item is in work
// result channel m_*: one beat per message with result and modulus_error
// zero exponent gives 1 with no error; zero modulus with a nonzero exponent
//   gives 0 with modulus_error set
// square-and-multiply over all WORD_BITS exponent bits, each modular product
//   formed in the one shared shift-add multiplier; the multiplier is not
//   used when the exponent or modulus is zero
// one message in work at a time, the next accepted as soon as the
//   result has moved to the output register
// reset (synchronous, active low) sets exponent and modulus to 1 and empties
//   the sequencer and output register
// a stalled receiver holds the result in the output register; the block can
//   take and work on one further message, which then waits until that beat goes
module modular_exponentiation_top import mexp_pkg::*; #(
    parameter int unsigned WORD_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // config write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]      cfg_data,
    // message channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [WORD_BITS-1:0]      s_message,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [WORD_BITS-1:0]      m_result,
    output logic                      m_modulus_error
);

    logic [WORD_BITS-1:0] exponent_reg;
    logic [WORD_BITS-1:0] modulus_reg;

    logic                 seq_idle;
    logic                 in_accept;
    logic                 mm_start;
    logic [WORD_BITS-1:0] mm_a, mm_b, mm_product;
    mexp_mm_stat_t        mm_stat;
    logic                 res_valid, res_error, res_taken;
    logic [WORD_BITS-1:0] res_value;

    logic                 m_valid_reg;
    logic [WORD_BITS-1:0] m_result_reg;
    logic                 m_error_reg;

    // config registers, writes always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exponent_reg <= WORD_BITS'(1);
            modulus_reg  <= WORD_BITS'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_EXPONENT: exponent_reg <= cfg_data;
                REG_MODULUS:  modulus_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // a message is taken whenever the sequencer is idle
    assign s_ready   = seq_idle;
    assign in_accept = s_valid && seq_idle;

    mexp_seq #(
        .WORD_BITS (WORD_BITS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .message    (s_message),
        .exponent   (exponent_reg),
        .modulus    (modulus_reg),
        .idle       (seq_idle),
        .mm_start   (mm_start),
        .mm_a       (mm_a),
        .mm_b       (mm_b),
        .mm_stat    (mm_stat),
        .mm_product (mm_product),
        .res_valid  (res_valid),
        .res_taken  (res_taken),
        .res_value  (res_value),
        .res_error  (res_error)
    );

    // the one shared modular multiplier, modulus taken at each start
    mexp_modmul #(
        .WORD_BITS (WORD_BITS)
    ) u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .op_m    (modulus_reg),
        .stat    (mm_stat),
        .product (mm_product)
    );

    // output register: loads when empty or when its beat leaves this cycle
    assign res_taken = res_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_taken) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_taken) begin
            m_result_reg <= res_value;
            m_error_reg  <= res_error;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result        = m_result_reg;
    assign m_modulus_error = m_error_reg;

    // the multiplier is never restarted while it is still iterating
    assert property (@(posedge aclk) disable iff (!aresetn)
        mm_start |-> !mm_stat.busy)
        else $error("multiplier started while busy");

    // a finished product only follows a running multiplication
    assert property (@(posedge aclk) disable iff (!aresetn)
        mm_stat.done |-> $past(mm_stat.busy))
        else $error("multiplier done without work");

    // an idle sequencer leaves the multiplier idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !mm_stat.busy)
        else $error("multiplier busy while sequencer idle");

    // an error beat always carries a zero result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_modulus_error) |-> (m_result == '0))
        else $error("modulus error with nonzero result");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import mexp_pkg::*;

    localparam int unsigned WORD_BITS = 16;

    // cfg indexes past the register list, written to check they are ignored
    localparam logic [CFG_INDEX_BITS-1:0] SPARE_INDEX_LO = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] SPARE_INDEX_HI = 2'd3;

    localparam int RANDOM_PHASES    = 12;
    localparam int MSGS_PER_PHASE   = 48;
    localparam int STEADY_PHASE     = 2;     // no idling on either side
    localparam int HOLD_PHASE       = 5;     // receiver holds off for a long stretch
    localparam int HOLD_CYCLES      = 3000;  // several latencies, so the block fills up
    localparam int IDLE_PERCENT     = 14;
    localparam int TAIL_CYCLES      = 700;   // long enough for a dense exponent
    localparam int STALL_LIMIT      = 20000;

    typedef struct packed {
        logic [WORD_BITS-1:0] value;
        logic                 modulus_error;
    } power_t;

    logic                      aclk;
    logic                      aresetn = 1'b0;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_EXPONENT;
    logic [WORD_BITS-1:0]      cfg_data = '0;

    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [WORD_BITS-1:0]      s_message = '0;

    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [WORD_BITS-1:0]      m_result;
    logic                      m_modulus_error;

    // messages waiting to be offered, and powers waiting to come back
    logic [WORD_BITS-1:0] outgoing_msgs[$];
    power_t               awaited_powers[$];

    // our own copy of the key registers, follows the cfg beats
    logic [WORD_BITS-1:0] key_exponent = WORD_BITS'(1);
    logic [WORD_BITS-1:0] key_modulus = WORD_BITS'(1);

    logic msg_taken = 1'b0;
    logic steady = 1'b0;
    int   msgs_queued = 0;
    int   msgs_accepted = 0;
    int   powers_seen = 0;
    int   flagged_powers = 0;
    int   key_settings = 0;
    int   errors = 0;
    int   hold_requests = 0;
    int   hold_served = 0;
    int   hold_left = 0;
    int   stall_cycles = 0;

    modular_exponentiation_top #(
        .WORD_BITS(WORD_BITS)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_message      (s_message),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result       (m_result),
        .m_modulus_error(m_modulus_error)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // message ^ exponent mod modulus by square-and-multiply over every exponent bit
    function automatic power_t modexp_predict(logic [WORD_BITS-1:0] msg,
                                              logic [WORD_BITS-1:0] expo,
                                              logic [WORD_BITS-1:0] modulus);
        power_t          p;
        longint unsigned acc;
        longint unsigned base;
        p.modulus_error = 1'b0;
        if (expo == 0) begin
            // no reduction at all, so 1 even for modulus 1 or 0
            p.value = WORD_BITS'(1);
        end else if (modulus == 0) begin
            p.value = '0;
            p.modulus_error = 1'b1;
        end else begin
            acc = 1;
            base = msg % modulus;    // message at or above the modulus folds here
            for (int b = 0; b < WORD_BITS; b++) begin
                if (expo[b])
                    acc = (acc * base) % modulus;
                base = (base * base) % modulus;
            end
            p.value = acc[WORD_BITS-1:0];
        end
        return p;
    endfunction

    // one cfg write, valid dropped again right after its beat
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [WORD_BITS-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // block is idle once every queued message has been taken and answered
    task automatic wait_idle();
        do @(negedge aclk);
        while (msgs_accepted != msgs_queued || awaited_powers.size() != 0);
    endtask

    // new key only while idle; ends on a rising edge so pushes never race the driver
    task automatic set_key(logic [WORD_BITS-1:0] expo, logic [WORD_BITS-1:0] modulus);
        wait_idle();
        write_reg(REG_EXPONENT, expo);
        write_reg(REG_MODULUS, modulus);
        key_settings++;
        @(posedge aclk);
    endtask

    task automatic queue_msg(logic [WORD_BITS-1:0] msg);
        outgoing_msgs.push_back(msg);
        msgs_queued++;
    endtask

    // stimulus: directed corners first, then random keys and messages
    initial begin
        logic [WORD_BITS-1:0] expo;
        logic [WORD_BITS-1:0] modulus;
        logic [WORD_BITS-1:0] msg;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset key: exponent 1, modulus 1, so every power reduces to 0
        queue_msg(16'h0000);
        queue_msg(16'hFFFF);
        queue_msg(16'h1234);

        // zero exponent wins over zero modulus: 1 with no flag
        set_key(16'd0, 16'd0);
        queue_msg(16'h0000);
        queue_msg(16'hFFFF);

        // zero modulus with a live exponent raises the flag
        set_key(16'd5, 16'd0);
        queue_msg(16'h0007);
        queue_msg(16'hFFFF);

        // zero exponent stays unreduced even with modulus 1
        set_key(16'd0, 16'd1);
        queue_msg(16'h0009);

        // small rsa pair, n = 61 * 53, e = 17, d = 2753
        set_key(16'd17, 16'd3233);
        queue_msg(16'd65);
        queue_msg(16'd3232);
        queue_msg(16'd3233);       // equal to the modulus
        queue_msg(16'hFFFF);       // well above it
        queue_msg(16'h0000);
        set_key(16'd2753, 16'd3233);
        queue_msg(16'd2790);
        queue_msg(16'd1);

        // everything at the top of the range
        set_key(16'hFFFF, 16'hFFFF);
        queue_msg(16'hFFFF);
        queue_msg(16'hFFFE);
        queue_msg(16'h0002);

        // writes past the register list must leave the key alone
        wait_idle();
        write_reg(SPARE_INDEX_LO, 16'h0000);
        write_reg(SPARE_INDEX_HI, 16'h0001);
        @(posedge aclk);
        queue_msg(16'hAAAA);
        queue_msg(16'h5555);

        set_key(16'hFFFF, 16'd2);
        queue_msg(16'h0001);
        queue_msg(16'h0003);
        set_key(16'd1, 16'd65521);
        queue_msg(16'hFFFF);

        // random keys, each phase drains completely before the next key
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(7))
                0:       expo = '0;
                1:       expo = 16'd1;
                2:       expo = 16'hFFFF;
                3:       expo = WORD_BITS'($urandom_range(31, 2));
                default: expo = WORD_BITS'($urandom);
            endcase
            case ($urandom_range(9))
                0:       modulus = '0;
                1:       modulus = 16'd1;
                2:       modulus = 16'd2;
                3:       modulus = 16'hFFFF;
                4:       modulus = WORD_BITS'($urandom_range(255, 3));
                default: modulus = WORD_BITS'($urandom);
            endcase
            set_key(expo, modulus);
            steady = (phase == STEADY_PHASE);
            for (int n = 0; n < MSGS_PER_PHASE; n++) begin
                case ($urandom_range(9))
                    0:       msg = '0;
                    1:       msg = 16'hFFFF;
                    2:       msg = modulus;
                    3:       msg = modulus - 1'b1;
                    default: msg = WORD_BITS'($urandom);
                endcase
                queue_msg(msg);
            end
            // receiver stops while the sender keeps offering
            if (phase == HOLD_PHASE)
                hold_requests++;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("covered %0d messages under %0d key settings plus the reset key",
                 msgs_accepted, key_settings);
        $display("%0d powers checked, %0d with the zero-modulus flag, one long receiver hold",
                 powers_seen, flagged_powers);
        if (errors == 0 && awaited_powers.size() == 0) begin
            $display("modular_exponentiation_top: match");
        end else begin
            $display("modular_exponentiation_top: mismatch");
        end
        $finish;
    end

    // message driver: new beat only once the previous one has gone
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || msg_taken) begin
            if (outgoing_msgs.size() != 0
                    && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
                s_valid <= 1'b1;
                s_message <= outgoing_msgs.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls, plus the long hold counted out here
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || $urandom_range(99) >= IDLE_PERCENT;
        end
    end

    // monitor: follows cfg beats, predicts on message beats, checks result beats
    always @(posedge aclk) begin
        power_t want;
        msg_taken <= s_valid && s_ready;
        if (!aresetn) begin
            key_exponent <= WORD_BITS'(1);
            key_modulus <= WORD_BITS'(1);
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_EXPONENT: key_exponent <= cfg_data;
                    REG_MODULUS:  key_modulus <= cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                awaited_powers.push_back(modexp_predict(s_message, key_exponent, key_modulus));
                msgs_accepted++;
            end
            if (m_valid && m_ready) begin
                powers_seen++;
                if (m_modulus_error)
                    flagged_powers++;
                if (awaited_powers.size() == 0) begin
                    $display("%0t: result beat %h flag %b with nothing awaited",
                             $time, m_result, m_modulus_error);
                    errors++;
                end else begin
                    want = awaited_powers.pop_front();
                    if (m_result !== want.value) begin
                        $display("%0t: result expected %h got %h",
                                 $time, want.value, m_result);
                        errors++;
                    end
                    if (m_modulus_error !== want.modulus_error) begin
                        $display("%0t: modulus_error expected %b got %b",
                                 $time, want.modulus_error, m_modulus_error);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, stall_cycles);
            $display("modular_exponentiation_top: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

// ----- filelist.f -----
sv/mexp_pkg.sv
sv/mexp_modmul.sv
sv/mexp_seq.sv
sv/modular_exponentiation_top.sv
sim/tb.sv
